// ----- hdl/keyframe_time_table_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef KEYFRAME_TIME_TABLE_TOP_DEFINES_SVH
`define KEYFRAME_TIME_TABLE_TOP_DEFINES_SVH

// Checked only while out of reset.
`define KFTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define KFTT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/kftt_pkg.sv -----
package kftt_pkg;

    localparam int IDX_W       = 6;
    localparam int KEY_CNT_W   = 7;
    localparam int FRAC_BITS   = 16;
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;
    localparam logic [31:0] ANIM_LEN_RST = 32'd65536;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        DIV_MOD  = 1'b0,
        DIV_FRAC = 1'b1
    } t_div_mode;

    typedef struct packed {
        logic      start;
        t_div_mode mode;
    } t_div_ctl;

    typedef struct packed {
        t_status                status;
        logic [IDX_W-1:0]       first_index;
        logic [IDX_W-1:0]       second_index;
        logic [FRAC_BITS-1:0]   fraction;
        logic                   same_key;
        logic [KEY_CNT_W-1:0]   key_count;
    } t_rsp;

endpackage

// ----- hdl/kftt_if.sv -----
interface kftt_req_if #(
    parameter int TIME_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [TIME_BITS-1:0] time_value;
    logic [5:0]           key_index;

    modport source (output valid, output req_type, output time_value, output key_index,
                    input ready);
    modport sink   (input valid, input req_type, input time_value, input key_index,
                    output ready);
endinterface

interface kftt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  first_index;
    logic [5:0]  second_index;
    logic [15:0] fraction;
    logic        same_key;
    logic [6:0]  key_count;

    modport source (output valid, output status, output first_index, output second_index,
                    output fraction, output same_key, output key_count, input ready);
    modport sink   (input valid, input status, input first_index, input second_index,
                    input fraction, input same_key, input key_count, output ready);
endinterface

// ----- hdl/kftt_ram.sv -----
module kftt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/kftt_div.sv -----
module kftt_div #(
    parameter int TIME_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kftt_pkg::t_div_ctl             i_ctl,
    input  logic [TIME_BITS-1:0]           i_num,
    input  logic [TIME_BITS:0]             i_den,
    output logic                           o_done,
    output logic [TIME_BITS-1:0]           o_rem,
    output logic [kftt_pkg::FRAC_BITS-1:0] o_quo
);

    localparam int REM_W     = TIME_BITS + 2;
    localparam int STEPS_MAX = (TIME_BITS > kftt_pkg::FRAC_BITS) ? TIME_BITS
                                                                 : kftt_pkg::FRAC_BITS;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [REM_W-1:0]               r_rem;
    logic [TIME_BITS-1:0]           r_dvd;
    logic [TIME_BITS:0]             r_den;
    logic [kftt_pkg::FRAC_BITS-1:0] r_quo;

    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] den_ext;
    logic [REM_W-1:0] diff;
    logic             fits;

    // one restoring step per cycle
    always_comb begin
        shifted = {r_rem[REM_W-2:0], r_dvd[TIME_BITS-1]};
        den_ext = {1'b0, r_den};
        fits    = (shifted >= den_ext);
        diff    = shifted - den_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.mode == kftt_pkg::DIV_MOD) ? CNT_W'(TIME_BITS)
                                                            : CNT_W'(kftt_pkg::FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_den <= i_den;
            r_quo <= '0;
            if (i_ctl.mode == kftt_pkg::DIV_MOD) begin
                r_rem <= '0;
                r_dvd <= i_num;
            end else begin
                r_rem <= REM_W'(i_num);
                r_dvd <= '0;
            end
        end else if (r_busy) begin
            r_rem <= fits ? diff : shifted;
            r_dvd <= {r_dvd[TIME_BITS-2:0], 1'b0};
            r_quo <= {r_quo[kftt_pkg::FRAC_BITS-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[TIME_BITS-1:0];
    assign o_quo  = r_quo;

endmodule

// ----- hdl/kftt_seq.sv -----
module kftt_seq #(
    parameter int MAX_KEYS  = 64,
    parameter int TIME_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kftt_req_if.sink                       i_req,
    kftt_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [TIME_BITS-1:0]           i_cfg_wdata,
    output logic                           o_ram_we,
    output logic [$clog2(MAX_KEYS)-1:0]    o_ram_waddr,
    output logic [TIME_BITS-1:0]           o_ram_wdata,
    output logic [$clog2(MAX_KEYS)-1:0]    o_ram_raddr,
    input  logic [TIME_BITS-1:0]           i_ram_rdata,
    output kftt_pkg::t_div_ctl             o_div_ctl,
    output logic [TIME_BITS-1:0]           o_div_num,
    output logic [TIME_BITS:0]             o_div_den,
    input  logic                           i_div_done,
    input  logic [TIME_BITS-1:0]           i_div_rem,
    input  logic [kftt_pkg::FRAC_BITS-1:0] i_div_quo
);

    localparam int AW    = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_RM_RD,
        S_RM_WR,
        S_LK_MOD,
        S_LK_RD,
        S_LK_CMP,
        S_LK_NUM,
        S_LK_FRAC,
        S_LK_DIV,
        S_FIN
    } t_state;

    t_state                         r_state;
    logic [CNT_W-1:0]               r_cnt;
    logic [CNT_W-1:0]               r_pos;
    logic [TIME_BITS-1:0]           r_len;
    logic                           r_out_valid;
    kftt_pkg::t_rsp                 r_rsp;
    kftt_pkg::t_div_ctl             r_div_ctl;
    kftt_pkg::t_status              r_status;
    logic [AW-1:0]                  r_first;
    logic [AW-1:0]                  r_second;
    logic [kftt_pkg::FRAC_BITS-1:0] r_frac;
    logic                           r_same;
    logic [TIME_BITS-1:0]           r_t;
    logic [TIME_BITS-1:0]           r_t1;
    logic [TIME_BITS:0]             r_t2;
    logic [TIME_BITS-1:0]           r_key0;
    logic [TIME_BITS-1:0]           r_prev;
    logic [TIME_BITS-1:0]           r_num;
    logic [TIME_BITS:0]             r_den;

    logic [TIME_BITS-1:0] len_eff;
    logic [CNT_W-1:0]     pos_inc;
    logic [CNT_W-1:0]     pos_dec;
    logic [CNT_W-1:0]     cnt_dec;
    logic [31:0]          first_ext;
    logic [31:0]          second_ext;
    logic [31:0]          cnt_ext;

    always_comb begin
        len_eff    = (r_len == '0) ? TIME_BITS'(1) : r_len;
        pos_inc    = r_pos + CNT_W'(1);
        pos_dec    = r_pos - CNT_W'(1);
        cnt_dec    = r_cnt - CNT_W'(1);
        first_ext  = 32'(r_first);
        second_ext = 32'(r_second);
        cnt_ext    = 32'(r_cnt);
    end

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_pos[AW-1:0];
        o_ram_wdata = r_t;
        o_ram_raddr = r_pos[AW-1:0];
        unique case (r_state)
            S_INS_RD: begin
                o_ram_raddr = pos_dec[AW-1:0];
                o_ram_we    = (r_pos == '0);
            end
            S_INS_CMP: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = (i_ram_rdata > r_t) ? i_ram_rdata : r_t;
            end
            S_RM_RD: begin
                o_ram_raddr = pos_inc[AW-1:0];
            end
            S_RM_WR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = i_ram_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_len       <= kftt_pkg::ANIM_LEN_RST[TIME_BITS-1:0];
            r_out_valid <= 1'b0;
            r_div_ctl   <= '0;
        end else begin
            r_div_ctl.start <= 1'b0;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_t      <= i_req.time_value;
                        r_status <= kftt_pkg::ST_OK;
                        r_first  <= '0;
                        r_second <= '0;
                        r_frac   <= '0;
                        r_same   <= 1'b0;
                        unique case (kftt_pkg::t_req'(i_req.req_type))
                            kftt_pkg::REQ_INSERT: begin
                                if (r_cnt == CNT_W'(MAX_KEYS)) begin
                                    r_status <= kftt_pkg::ST_FULL;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_pos   <= r_cnt;
                                    r_state <= S_INS_RD;
                                end
                            end
                            kftt_pkg::REQ_REMOVE: begin
                                if (32'(i_req.key_index) >= 32'(r_cnt)) begin
                                    r_status <= kftt_pkg::ST_BAD_INDEX;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_pos   <= CNT_W'(i_req.key_index);
                                    r_state <= S_RM_RD;
                                end
                            end
                            kftt_pkg::REQ_CLEAR: begin
                                r_cnt   <= '0;
                                r_state <= S_FIN;
                            end
                            kftt_pkg::REQ_LOOKUP: begin
                                r_pos <= '0;
                                if (r_cnt == '0) begin
                                    r_status <= kftt_pkg::ST_EMPTY;
                                    r_state  <= S_FIN;
                                end else if (i_req.time_value >= len_eff) begin
                                    r_num     <= i_req.time_value;
                                    r_den     <= {1'b0, len_eff};
                                    r_div_ctl <= '{start: 1'b1, mode: kftt_pkg::DIV_MOD};
                                    r_state   <= S_LK_MOD;
                                end else begin
                                    r_state <= S_LK_RD;
                                end
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (r_pos == '0) begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_first <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (i_ram_rdata > r_t) begin
                        r_pos   <= pos_dec;
                        r_state <= S_INS_RD;
                    end else begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_first <= r_pos[AW-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_RM_RD: begin
                    if (pos_inc < r_cnt) begin
                        r_state <= S_RM_WR;
                    end else begin
                        r_cnt   <= cnt_dec;
                        r_state <= S_FIN;
                    end
                end
                S_RM_WR: begin
                    r_pos   <= pos_inc;
                    r_state <= S_RM_RD;
                end
                S_LK_MOD: begin
                    if (i_div_done) begin
                        r_t     <= i_div_rem;
                        r_state <= S_LK_RD;
                    end
                end
                S_LK_RD: begin
                    if (r_pos == r_cnt) begin
                        // every key at or below the time: wrap to the first key
                        r_first  <= cnt_dec[AW-1:0];
                        r_second <= '0;
                        r_t1     <= r_prev;
                        r_t2     <= {1'b0, len_eff} + {1'b0, r_key0};
                        r_state  <= S_LK_NUM;
                    end else begin
                        r_state <= S_LK_CMP;
                    end
                end
                S_LK_CMP: begin
                    if (r_pos == '0) begin
                        r_key0 <= i_ram_rdata;
                    end
                    if (i_ram_rdata > r_t) begin
                        r_second <= r_pos[AW-1:0];
                        r_t2     <= {1'b0, i_ram_rdata};
                        if (r_pos == '0) begin
                            r_first <= '0;
                            r_t1    <= i_ram_rdata;
                        end else begin
                            r_first <= pos_dec[AW-1:0];
                            r_t1    <= r_prev;
                        end
                        r_state <= S_LK_NUM;
                    end else begin
                        r_prev  <= i_ram_rdata;
                        r_pos   <= pos_inc;
                        r_state <= S_LK_RD;
                    end
                end
                S_LK_NUM: begin
                    if ({1'b0, r_t1} == r_t2) begin
                        r_num <= r_t;
                        r_den <= r_t2;
                    end else begin
                        r_num <= (r_t >= r_t1) ? r_t - r_t1 : '0;
                        r_den <= (r_t2 > {1'b0, r_t1}) ? r_t2 - {1'b0, r_t1} : '0;
                    end
                    r_same  <= (r_first == r_second);
                    r_state <= S_LK_FRAC;
                end
                S_LK_FRAC: begin
                    if (r_den == '0) begin
                        r_frac  <= (r_num != '0) ? kftt_pkg::FRAC_MAX : '0;
                        r_state <= S_FIN;
                    end else if ({1'b0, r_num} >= r_den) begin
                        r_frac  <= kftt_pkg::FRAC_MAX;
                        r_state <= S_FIN;
                    end else begin
                        r_div_ctl <= '{start: 1'b1, mode: kftt_pkg::DIV_FRAC};
                        r_state   <= S_LK_DIV;
                    end
                end
                S_LK_DIV: begin
                    if (i_div_done) begin
                        r_frac  <= i_div_quo;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_rsp.status       <= r_status;
                        r_rsp.first_index  <= first_ext[kftt_pkg::IDX_W-1:0];
                        r_rsp.second_index <= second_ext[kftt_pkg::IDX_W-1:0];
                        r_rsp.fraction     <= r_frac;
                        r_rsp.same_key     <= r_same;
                        r_rsp.key_count    <= cnt_ext[kftt_pkg::KEY_CNT_W-1:0];
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.first_index  = r_rsp.first_index;
    assign o_rsp.second_index = r_rsp.second_index;
    assign o_rsp.fraction     = r_rsp.fraction;
    assign o_rsp.same_key     = r_rsp.same_key;
    assign o_rsp.key_count    = r_rsp.key_count;

    assign o_div_ctl = r_div_ctl;
    assign o_div_num = r_num;
    assign o_div_den = r_den;

endmodule

// ----- hdl/keyframe_time_table_top.sv -----
// Sorted key frame time table with bracket lookup.
// i_req carries one request word (insert, remove, clear, lookup); o_rsp returns
// exactly one result word per request. Both use valid/ready; a word moves on a
// clock edge with valid and ready high. i_cfg_we/i_cfg_wdata write anim_length;
// the user must write it only while the table is idle; the block does not enforce this.
// One request is worked at a time; i_req.ready is high only between requests.
// Clear and the error cases go straight to the result. Insert moves the keys
// above its position up by one while it seeks its place; remove moves the keys
// above the removed index down by one. Lookup divides to wrap a time at or past
// anim_length, scans up to the bracket, then divides for the fraction if needed.
// The scan and shift move one key at a time through the key memory's single
// registered read port; wrap and fraction share one bit-serial divider.
// A finished result sits in an output register; the next request is taken while
// it waits, and its own result is held until o_rsp.ready frees the register.
// Synchronous reset empties the table, sets anim_length to 65536 and drops
// o_rsp.valid; the key memory itself is not cleared.
module keyframe_time_table_top #(
    parameter int MAX_KEYS  = 64,
    parameter int TIME_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kftt_req_if.sink             i_req,
    kftt_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [TIME_BITS-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(MAX_KEYS);

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [TIME_BITS-1:0]           ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [TIME_BITS-1:0]           ram_rdata;
    kftt_pkg::t_div_ctl             div_ctl;
    logic [TIME_BITS-1:0]           div_num;
    logic [TIME_BITS:0]             div_den;
    logic                           div_done;
    logic [TIME_BITS-1:0]           div_rem;
    logic [kftt_pkg::FRAC_BITS-1:0] div_quo;

    kftt_seq #(
        .MAX_KEYS  (MAX_KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_div_ctl   (div_ctl),
        .o_div_num   (div_num),
        .o_div_den   (div_den),
        .i_div_done  (div_done),
        .i_div_rem   (div_rem),
        .i_div_quo   (div_quo)
    );

    kftt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kftt_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_rem   (div_rem),
        .o_quo   (div_quo)
    );

endmodule

// ----- hdl/kftt_chk.sv -----
`include "keyframe_time_table_top_defines.svh"

module kftt_chk #(
    parameter int MAX_KEYS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [5:0]  i_rsp_first_index,
    input logic [5:0]  i_rsp_second_index,
    input logic [15:0] i_rsp_fraction,
    input logic        i_rsp_same_key,
    input logic [6:0]  i_rsp_key_count
);

    `KFTT_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!i_rsp_valid && i_req_ready), "reset must drop the result and open the request side")

    `KFTT_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_first_index) && $stable(i_rsp_second_index) && $stable(i_rsp_fraction) && $stable(i_rsp_same_key) && $stable(i_rsp_key_count)), "stalled result word changed")

    `KFTT_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready, "request taken while one is in progress")

    `KFTT_ASSERT(a_empty_result, i_clk, i_rst_n, (i_rsp_valid && (i_rsp_status == kftt_pkg::ST_EMPTY)) |-> (i_rsp_key_count == '0 && i_rsp_fraction == '0 && !i_rsp_same_key), "empty lookup result not cleared")

    `KFTT_ASSERT(a_count_bound, i_clk, i_rst_n, i_rsp_valid |-> (32'(i_rsp_key_count) <= 32'(MAX_KEYS)), "key count beyond table size")

endmodule

bind keyframe_time_table_top kftt_chk #(
    .MAX_KEYS (MAX_KEYS)
) u_kftt_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_first_index  (o_rsp.first_index),
    .i_rsp_second_index (o_rsp.second_index),
    .i_rsp_fraction     (o_rsp.fraction),
    .i_rsp_same_key     (o_rsp.same_key),
    .i_rsp_key_count    (o_rsp.key_count)
);
